FILE: sv/hsb2rgb_pkg.sv
// ---------------------------------------------------------------------------
// hsb2rgb_pkg
// Shared widths, fixed-point constants and types for the HSB to RGB pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package hsb2rgb_pkg;

  // Fixed point: One = 2^FracBits means 1.0
  localparam int unsigned FracBits = 12;
  localparam int unsigned LevelW   = 13;
  // 6 * One needs two more bits than a level
  localparam int unsigned RampW    = LevelW + 2;

  typedef logic [LevelW-1:0] level_t;
  typedef logic [RampW-1:0]  ramp_t;

  localparam level_t One   = level_t'(2 ** FracBits);
  localparam ramp_t  Ramp1 = ramp_t'(1 * (2 ** FracBits));
  localparam ramp_t  Ramp2 = ramp_t'(2 * (2 ** FracBits));
  localparam ramp_t  Ramp3 = ramp_t'(3 * (2 ** FracBits));
  localparam ramp_t  Ramp4 = ramp_t'(4 * (2 ** FracBits));
  localparam ramp_t  Ramp5 = ramp_t'(5 * (2 ** FracBits));
  localparam ramp_t  Ramp6 = ramp_t'(6 * (2 ** FracBits));

  // Load enables for the two channel stages
  typedef struct packed {
    logic ld_mul;
    logic ld_out;
  } stg_en_t;

  // Inputs above 1.0 clamp to 1.0
  function automatic level_t sat_in(level_t v);
    return (v > One) ? One : v;
  endfunction

endpackage

`default_nettype wire

FILE: sv/hue_sat_bright_to_rgb.sv
// ---------------------------------------------------------------------------
// hue_sat_bright_to_rgb
// Fixed-point HSB to RGB converter, four-stage pipeline with backpressure.
// ---------------------------------------------------------------------------
// All levels are unsigned fixed point with 4096 meaning 1.0; inputs above
// 4096 clamp to 4096. The block takes one word per clock unless stalled and
// returns one result word for each, in order. A result can leave once it
// reaches the last stage and the output side is ready. The four register
// stages are: input clamp and hue*6, sector select, the whitening multiply
// (one 13x13 multiplier per channel), and the add/clamp/dim that feeds the
// output register. Each stage carries its own valid bit and holds while the
// stage after it is full and stalled, so empty stages keep taking words while
// a result waits; ready goes low only once all four stages are occupied and
// the output is stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module hue_sat_bright_to_rgb import hsb2rgb_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  // input channel
  input  wire logic   in_valid_i,
  output logic        in_ready_o,
  input  wire level_t hue_i,
  input  wire level_t saturation_i,
  input  wire level_t brightness_i,
  // output channel
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output level_t      red_level_o,
  output level_t      green_level_o,
  output level_t      blue_level_o
);

  // Stage valid bits and per-stage ready (stage can load)
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || out_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // ---- Stage 1: clamp inputs, t = 6*hue, inv = One - brightness ----------
  level_t h_sat, b_sat;
  ramp_t  t_d;
  ramp_t  t1_q;
  level_t s1_q, inv1_q;

  assign h_sat = sat_in(hue_i);
  assign b_sat = sat_in(brightness_i);
  // 6h = 4h + 2h
  assign t_d   = ramp_t'({h_sat, 2'b00}) + ramp_t'({h_sat, 1'b0});

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      t1_q   <= t_d;
      s1_q   <= sat_in(saturation_i);
      inv1_q <= One - b_sat;
    end
  end

  // ---- Stage 2: sector select; upper bound belongs to the sector ---------
  level_t r_d, g_d, bl_d;
  level_t r2_q, g2_q, bl2_q, s2_q, inv2_q;

  always_comb begin
    if (t1_q <= Ramp1) begin
      r_d = One;  g_d = level_t'(t1_q);          bl_d = '0;
    end else if (t1_q <= Ramp2) begin
      r_d = level_t'(Ramp2 - t1_q); g_d = One;   bl_d = '0;
    end else if (t1_q <= Ramp3) begin
      r_d = '0;   g_d = One;  bl_d = level_t'(t1_q - Ramp2);
    end else if (t1_q <= Ramp4) begin
      r_d = '0;   g_d = level_t'(Ramp4 - t1_q);  bl_d = One;
    end else if (t1_q <= Ramp5) begin
      r_d = level_t'(t1_q - Ramp4); g_d = '0;    bl_d = One;
    end else begin
      r_d = One;  g_d = '0;   bl_d = level_t'(Ramp6 - t1_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      r2_q   <= r_d;
      g2_q   <= g_d;
      bl2_q  <= bl_d;
      s2_q   <= s1_q;
      inv2_q <= inv1_q;
    end
  end

  // ---- Stages 3 and 4: whiten and dim, one unit per channel --------------
  level_t  inv3_q;
  stg_en_t chan_en;
  logic    unused_r, unused_g, unused_b;

  assign chan_en.ld_mul = rdy3;
  assign chan_en.ld_out = rdy4;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      inv3_q <= inv2_q;
    end
  end

  hsb2rgb_chan u_red (
    .clk_i                (clk_i),
    .en_i                 (chan_en),
    .chan_i               (r2_q),
    .sat_i                (s2_q),
    .inv_i                (inv3_q),
    .level_dummy_unused_o (unused_r),
    .level_o              (red_level_o)
  );

  hsb2rgb_chan u_green (
    .clk_i                (clk_i),
    .en_i                 (chan_en),
    .chan_i               (g2_q),
    .sat_i                (s2_q),
    .inv_i                (inv3_q),
    .level_dummy_unused_o (unused_g),
    .level_o              (green_level_o)
  );

  hsb2rgb_chan u_blue (
    .clk_i                (clk_i),
    .en_i                 (chan_en),
    .chan_i               (bl2_q),
    .sat_i                (s2_q),
    .inv_i                (inv3_q),
    .level_dummy_unused_o (unused_b),
    .level_o              (blue_level_o)
  );

  assign in_ready_o  = rdy1 && !(unused_r || unused_g || unused_b);
  assign out_valid_o = v4_q;

  // ---- Assertions --------------------------------------------------------
  // An empty first stage always takes a word.
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> in_ready_o)
    else $error("first stage empty but input not ready");

  // An accepted word lands in stage 1.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v1_q)
    else $error("accepted word lost at stage 1");

  // A word stalled in the middle of the pipe stays put.
  a_mid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !rdy3 |=> v2_q && $stable(r2_q) && $stable(g2_q) && $stable(bl2_q))
    else $error("stalled stage 2 word changed");

  // Results never exceed full scale.
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> red_level_o <= One && green_level_o <= One
                    && blue_level_o <= One)
    else $error("output level above full scale");

endmodule

`default_nettype wire

FILE: sv/hsb2rgb_chan.sv
// ---------------------------------------------------------------------------
// hsb2rgb_chan
// One color channel: whitening multiply, then clamp and brightness dimming.
// ---------------------------------------------------------------------------
`default_nettype none

module hsb2rgb_chan import hsb2rgb_pkg::*; (
  input  wire logic    clk_i,
  input  wire stg_en_t en_i,
  input  wire level_t  chan_i,   // ramp value, stage 2
  input  wire level_t  sat_i,    // saturation, stage 2
  input  wire level_t  inv_i,    // One - brightness, stage 3
  output logic         level_dummy_unused_o,
  output level_t       level_o
);

  level_t                  diff;
  logic [2*LevelW-1:0]     prod;
  level_t                  chan_q, whit_q, level_q;
  logic [LevelW:0]         sum;
  level_t                  clamped, level_d;

  // Stage 3: (One - c) * s, truncated
  assign diff = One - chan_i;
  assign prod = (2*LevelW)'(diff) * (2*LevelW)'(sat_i);

  always_ff @(posedge clk_i) begin
    if (en_i.ld_mul) begin
      chan_q <= chan_i;
      whit_q <= prod[FracBits +: LevelW];
    end
  end

  // Stage 4: add, clamp to One, subtract (One - b), clamp at zero
  always_comb begin
    sum     = {1'b0, chan_q} + {1'b0, whit_q};
    clamped = (sum > {1'b0, One}) ? One : sum[LevelW-1:0];
    level_d = (clamped > inv_i) ? (clamped - inv_i) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.ld_out) begin
      level_q <= level_d;
    end
  end

  assign level_o              = level_q;
  assign level_dummy_unused_o = 1'b0;

endmodule

`default_nettype wire

FILE: test/hue_sat_bright_to_rgb_tb.sv
// ---------------------------------------------------------------------------
// hue_sat_bright_to_rgb_tb
// Self-checking bench for the HSB to RGB converter: a directed table, then
// random words, with random gaps on the input side and random stalls on the
// output side, each result checked field by field against table or predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module hue_sat_bright_to_rgb_tb import hsb2rgb_pkg::*;;

  // Cycles with no word moving on either side before the run is abandoned.
  // Worst legal case is a long output stall plus a long input gap plus
  // pipeline fill.
  localparam int StallLimit  = 2000;
  localparam int NumRandom   = 1400;
  localparam int NumDirected = 22;
  localparam int unsigned OneI = 1 << FracBits;

  typedef struct packed {
    level_t red;
    level_t green;
    level_t blue;
  } rgb_t;

  // Directed row: inputs, whether the result is typed in, and that result
  typedef struct packed {
    level_t hue;
    level_t sat;
    level_t bright;
    bit     known;
    rgb_t   rgb;
  } hsb_row_t;

  logic   clk = 1'b0;
  logic   rst_n;
  logic   in_valid;
  logic   in_ready;
  level_t hue;
  level_t saturation;
  level_t brightness;
  logic   out_valid;
  logic   out_ready;
  level_t red_level;
  level_t green_level;
  level_t blue_level;

  rgb_t pending_rgb [$];
  int   errors;
  int   n_sent;
  int   n_checked;
  int   n_over_range;
  bit   no_gaps;

  // Directed words. Rows with known = 1 carry an obvious result; the rest
  // (sector edges, odd bit patterns, mid-range mixes) use the predictor.
  hsb_row_t directed_rows [NumDirected] = '{
    '{0,    0,    0,    1'b1, '{0,    0,    0   }},  // zero brightness: black
    '{0,    0,    4096, 1'b1, '{4096, 0,    0   }},  // pure red
    '{4096, 0,    4096, 1'b1, '{4096, 0,    0   }},  // full turn lands on red
    '{2048, 0,    4096, 1'b1, '{0,    4096, 4096}},  // cyan, exact sector bound
    '{0,    4096, 4096, 1'b1, '{4096, 4096, 4096}},  // full whitening
    '{8191, 8191, 8191, 1'b1, '{4096, 4096, 4096}},  // all fields above range
    '{4097, 0,    4097, 1'b1, '{4096, 0,    0   }},  // just above one
    '{1365, 4096, 0,    1'b1, '{0,    0,    0   }},  // dark beats white
    '{682,  0,    4096, 1'b0, '{0,    0,    0   }},  // top of red-yellow ramp
    '{683,  0,    4096, 1'b0, '{0,    0,    0   }},
    '{1365, 0,    4096, 1'b0, '{0,    0,    0   }},
    '{1366, 0,    4096, 1'b0, '{0,    0,    0   }},
    '{2730, 0,    4096, 1'b0, '{0,    0,    0   }},
    '{2731, 0,    4096, 1'b0, '{0,    0,    0   }},
    '{3413, 0,    4096, 1'b0, '{0,    0,    0   }},
    '{3414, 0,    4096, 1'b0, '{0,    0,    0   }},
    '{4095, 2048, 3000, 1'b0, '{0,    0,    0   }},
    '{500,  1,    4095, 1'b0, '{0,    0,    0   }},
    '{1700, 4095, 1,    1'b0, '{0,    0,    0   }},
    '{6826, 5461, 2730, 1'b0, '{0,    0,    0   }},  // alternating bits
    '{2730, 2730, 5461, 1'b0, '{0,    0,    0   }},
    '{1024, 2048, 2048, 1'b0, '{0,    0,    0   }}
  };

  hue_sat_bright_to_rgb dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .hue_i         (hue),
    .saturation_i  (saturation),
    .brightness_i  (brightness),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .red_level_o   (red_level),
    .green_level_o (green_level),
    .blue_level_o  (blue_level)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expected color for one word: clamp, hue sector ramp, whiten, dim.
  function automatic rgb_t predict_rgb(level_t h_in, level_t s_in, level_t b_in);
    int unsigned h, s, b, t, inv;
    int unsigned c [3];
    rgb_t res;
    h = (h_in > OneI) ? OneI : h_in;
    s = (s_in > OneI) ? OneI : s_in;
    b = (b_in > OneI) ? OneI : b_in;
    t = h * 6;
    // upper bound of each sector belongs to that sector
    if (t <= OneI) begin
      c = '{OneI, t, 0};
    end else if (t <= 2 * OneI) begin
      c = '{2 * OneI - t, OneI, 0};
    end else if (t <= 3 * OneI) begin
      c = '{0, OneI, t - 2 * OneI};
    end else if (t <= 4 * OneI) begin
      c = '{0, 4 * OneI - t, OneI};
    end else if (t <= 5 * OneI) begin
      c = '{t - 4 * OneI, 0, OneI};
    end else begin
      c = '{OneI, 0, 6 * OneI - t};
    end
    inv = OneI - b;
    for (int i = 0; i < 3; i++) begin
      c[i] = c[i] + (((OneI - c[i]) * s) >> FracBits);
      if (c[i] > OneI) c[i] = OneI;
      c[i] = (c[i] > inv) ? c[i] - inv : 0;
    end
    res.red   = level_t'(c[0]);
    res.green = level_t'(c[1]);
    res.blue  = level_t'(c[2]);
    return res;
  endfunction

  // Random field: weighted toward 0, one and above-range values
  function automatic level_t rand_level();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return level_t'(OneI);
    if (r < 26) return level_t'($urandom_range(OneI + 1, 8191));
    return level_t'($urandom_range(0, OneI));
  endfunction

  // Hue: some words land within two steps of a sector boundary
  function automatic level_t rand_hue();
    int unsigned k;
    if ($urandom_range(0, 99) < 15) begin
      k = $urandom_range(0, 6);
      return level_t'((k * OneI) / 6 + $urandom_range(0, 2));
    end
    return rand_level();
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Present one word, hold it until accepted, then queue its expected color.
  // in_ready is read right after the edge, i.e. the value the edge saw.
  task automatic send_word(level_t h, level_t s, level_t b, rgb_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    hue        <= h;
    saturation <= s;
    brightness <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_rgb.push_back(want);
    n_sent++;
    if (h > OneI || s > OneI || b > OneI) n_over_range++;
  endtask

  task automatic check_level(string field, level_t want, level_t got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      errors++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin : check_rgb
    rgb_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_rgb.size() == 0) begin
        $error("result word with no expectation pending");
        errors++;
      end else begin
        want = pending_rgb.pop_front();
        check_level("red_level", want.red, red_level);
        check_level("green_level", want.green, green_level);
        check_level("blue_level", want.blue, blue_level);
        n_checked++;
      end
    end
  end

  // Output backpressure: long open stretches, short and long stalls
  initial begin : drive_out_ready
    int unsigned r;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(50, 150)) @(posedge clk);
      end else if (r < 60) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else if (r < 95) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  // Watchdog: abandons the run when no word moves for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (idle < StallLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("Timeout: no word moved for %0d cycles", StallLimit);
    $display("Simulation FAILED");
    $finish;
  end

  // Main stimulus
  initial begin : stimulus
    level_t h, s, b;
    errors       = 0;
    n_sent       = 0;
    n_checked    = 0;
    n_over_range = 0;
    no_gaps      = 1'b0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    hue        <= '0;
    saturation <= '0;
    brightness <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NumDirected; i++) begin
      h = directed_rows[i].hue;
      s = directed_rows[i].sat;
      b = directed_rows[i].bright;
      send_word(h, s, b, directed_rows[i].known ? directed_rows[i].rgb
                                                : predict_rgb(h, s, b));
    end

    for (int i = 0; i < NumRandom; i++) begin
      // back-to-back bursts every few hundred words
      no_gaps = (i % 300) < 80;
      h = rand_hue();
      s = rand_level();
      b = rand_level();
      send_word(h, s, b, predict_rgb(h, s, b));
    end
    in_valid  <= 1'b0;

    while (pending_rgb.size() > 0) @(posedge clk);
    // pipeline is four deep; allow some margin for stray result words
    repeat (12) @(posedge clk);

    $display("Converted %0d words (%0d directed, %0d random), %0d checked",
             n_sent, NumDirected, NumRandom, n_checked);
    $display("%0d words had a field above 1.0; %0d mismatches", n_over_range, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
